// File: hdl/vlfa_pkg.sv
// video line fetch address: shared types, register codes and constants
// no dependencies; used by video_line_fetch_address (vlfa_div does not use it)
package vlfa_pkg;

   localparam int ADDRESS_BITS_DEFAULT = 24;
   localparam int PERIOD_BITS          = 12;

   localparam logic [25:0] SYS_CLOCK_HZ   = 26'd62500000;
   localparam logic [26:0] VIDEO_CLK_RST  = 27'd48681812;
   localparam logic [17:0] CYCLES_MAX     = 18'h3ffff;
   localparam logic [19:0] INTERVAL_MAX   = 20'hfffff;

   localparam logic [1:0] FMT_RGB16 = 2'd2;
   localparam logic [1:0] FMT_RGB32 = 2'd3;

   typedef enum logic [2:0] {
      REG_PIXEL_FORMAT,
      REG_FRAME_ORIGIN,
      REG_LINE_WIDTH,
      REG_ACTIVE_START,
      REG_ACTIVE_END,
      REG_ROW_OFFSET,
      REG_ROW_STEP,
      REG_VIDEO_CLOCK
   } reg_index_type;

   typedef struct packed {
      logic [9:0]             current_half_line;
      logic [15:0]            line_position;
      logic [PERIOD_BITS-1:0] line_period;
      logic                   fetch_enable;
   } req_type;

   typedef struct packed {
      logic        address_valid;
      logic [23:0] fetch_address;
      logic [17:0] line_system_cycles;
      logic [19:0] fetch_interval;
   } rsp_type;

endpackage

// File: hdl/vlfa_div.sv
// pipelined restoring divider, one quotient bit per register stage
// standalone; instantiated by video_line_fetch_address
module vlfa_div #(
   parameter int NUM_W  = 39,
   parameter int DEN_W  = 27,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   input  logic [SIDE_W-1:0] side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  quo,
   output logic [SIDE_W-1:0] out_side
);

   logic [NUM_W-1:0]  vld_ff;
   logic [DEN_W-1:0]  rem_ff  [NUM_W];
   logic [NUM_W-1:0]  num_ff  [NUM_W];
   logic [NUM_W-1:0]  quo_ff  [NUM_W];
   logic [DEN_W-1:0]  den_ff  [NUM_W];
   logic [SIDE_W-1:0] side_ff [NUM_W];

   for (genvar g = 0; g < NUM_W; g++) begin : g_stage
      logic              vld_prev;
      logic [DEN_W-1:0]  rem_prev;
      logic [NUM_W-1:0]  num_prev;
      logic [NUM_W-1:0]  quo_prev;
      logic [DEN_W-1:0]  den_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [DEN_W:0]    trial;
      logic              fits;
      logic [DEN_W-1:0]  rem_in;
      logic [NUM_W-1:0]  quo_in;

      if (g == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign rem_prev  = '0;
         assign num_prev  = num;
         assign quo_prev  = '0;
         assign den_prev  = den;
         assign side_prev = side;
      end else begin : g_next
         assign vld_prev  = vld_ff[g-1];
         assign rem_prev  = rem_ff[g-1];
         assign num_prev  = num_ff[g-1];
         assign quo_prev  = quo_ff[g-1];
         assign den_prev  = den_ff[g-1];
         assign side_prev = side_ff[g-1];
      end

      // shift in the next numerator bit and try the subtraction
      always_comb begin
         trial  = {rem_prev, num_prev[NUM_W-1-g]};
         fits   = trial >= {1'b0, den_prev};
         rem_in = fits ? DEN_W'(trial - {1'b0, den_prev}) : trial[DEN_W-1:0];
         quo_in = quo_prev;
         quo_in[NUM_W-1-g] = fits;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (en) begin
            vld_ff[g] <= vld_prev;
         end
         if (en) begin
            rem_ff[g]  <= rem_in;
            num_ff[g]  <= num_prev;
            quo_ff[g]  <= quo_in;
            den_ff[g]  <= den_prev;
            side_ff[g] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[NUM_W-1];
   assign quo       = quo_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

// File: hdl/video_line_fetch_address.sv
// path: stages a to c, the parallel dividers, interval divider, output register
// throughput: one item per cycle, set by the fully pipelined dividers
// (one quotient bit per stage for the cycle count, progress and fetch interval)
// a stalled result freezes the whole pipeline; no item is lost or repeated
// synchronous reset clears valid bits and loads register reset values
module video_line_fetch_address #(
   parameter int ADDRESS_BITS = vlfa_pkg::ADDRESS_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  vlfa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output vlfa_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam int PERIOD_BITS = vlfa_pkg::PERIOD_BITS;
   localparam int N1_W  = PERIOD_BITS + 27;
   localparam int N2_W  = 35;
   localparam int SUM_W = 27;
   localparam int MSK_B = (ADDRESS_BITS < SUM_W) ? ADDRESS_BITS : SUM_W;
   localparam logic [SUM_W-1:0] ADDR_MASK = {SUM_W{1'b1}} >> (SUM_W - MSK_B);

   // configuration registers
   logic [1:0]  fmt_ff;
   logic [23:0] origin_ff;
   logic [11:0] width_ff;
   logic [9:0]  start_ff;
   logic [9:0]  end_ff;
   logic [11:0] offset_ff;
   logic [11:0] step_ff;
   logic [26:0] vclk_ff;
   vlfa_pkg::reg_index_type reg_idx;

   assign reg_idx = vlfa_pkg::reg_index_type'(paddr[4:2]);
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff    <= '0;
         origin_ff <= '0;
         width_ff  <= '0;
         start_ff  <= '0;
         end_ff    <= '0;
         offset_ff <= '0;
         step_ff   <= '0;
         vclk_ff   <= vlfa_pkg::VIDEO_CLK_RST;
      end else if (psel && penable && pwrite) begin
         case (reg_idx)
            vlfa_pkg::REG_PIXEL_FORMAT: fmt_ff    <= pwdata[1:0];
            vlfa_pkg::REG_FRAME_ORIGIN: origin_ff <= pwdata[23:0];
            vlfa_pkg::REG_LINE_WIDTH:   width_ff  <= pwdata[11:0];
            vlfa_pkg::REG_ACTIVE_START: start_ff  <= pwdata[9:0];
            vlfa_pkg::REG_ACTIVE_END:   end_ff    <= pwdata[9:0];
            vlfa_pkg::REG_ROW_OFFSET:   offset_ff <= pwdata[11:0];
            vlfa_pkg::REG_ROW_STEP:     step_ff   <= pwdata[11:0];
            vlfa_pkg::REG_VIDEO_CLOCK:  vclk_ff   <= pwdata[26:0];
            default: ;
         endcase
      end
   end

   // register read back
   always_comb begin
      case (reg_idx)
         vlfa_pkg::REG_PIXEL_FORMAT: prdata = 32'(fmt_ff);
         vlfa_pkg::REG_FRAME_ORIGIN: prdata = 32'(origin_ff);
         vlfa_pkg::REG_LINE_WIDTH:   prdata = 32'(width_ff);
         vlfa_pkg::REG_ACTIVE_START: prdata = 32'(start_ff);
         vlfa_pkg::REG_ACTIVE_END:   prdata = 32'(end_ff);
         vlfa_pkg::REG_ROW_OFFSET:   prdata = 32'(offset_ff);
         vlfa_pkg::REG_ROW_STEP:     prdata = 32'(step_ff);
         vlfa_pkg::REG_VIDEO_CLOCK:  prdata = 32'(vclk_ff);
         default:                    prdata = '0;
      endcase
   end

   // global advance: the pipeline moves unless a result waits stalled
   logic adv;
   logic rsp_valid_ff;
   vlfa_pkg::rsp_type rsp_data_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // zero clock counts as one
   logic [26:0] clk_eff;
   assign clk_eff = (vclk_ff == '0) ? 27'd1 : vclk_ff;

   // stage a: line bytes, clipped position, clamped row
   logic [13:0]            lb_in;
   logic [PERIOD_BITS-1:0] period_in;
   logic [16:0]            pos_lim;
   logic [15:0]            pos_in;
   logic signed [11:0]     diff;
   logic signed [11:0]     rows;
   logic signed [11:0]     last;
   logic signed [11:0]     row_s;
   logic signed [11:0]     row_c;

   always_comb begin
      case (fmt_ff)
         vlfa_pkg::FMT_RGB32: lb_in = {width_ff, 2'b00};
         vlfa_pkg::FMT_RGB16: lb_in = {1'b0, width_ff, 1'b0};
         default:             lb_in = '0;
      endcase
      period_in  = req_data.line_period;
      pos_lim    = 17'(period_in) - 17'd1;
      pos_in     = (17'(req_data.line_position) < pos_lim) ? req_data.line_position
                                                           : pos_lim[15:0];
      // window row count, halved with truncation toward zero
      diff  = $signed({2'b00, end_ff}) - $signed({2'b00, start_ff});
      rows  = (diff + $signed({11'd0, diff[11]})) >>> 1;
      last  = (rows - 12'sd1 > 12'sd0) ? rows - 12'sd1 : 12'sd0;
      row_s = $signed({3'b000, req_data.current_half_line[9:1]})
            - $signed({3'b000, start_ff[9:1]});
      if (row_s < 12'sd0) begin
         row_c = 12'sd0;
      end else if (row_s > last) begin
         row_c = last;
      end else begin
         row_c = row_s;
      end
   end

   logic                   a_vld_ff;
   logic [PERIOD_BITS-1:0] a_period_ff;
   logic [15:0]            a_pos_ff;
   logic [13:0]            a_lb_ff;
   logic [8:0]             a_row_ff;
   logic                   a_fetch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= req_valid;
      end
      if (adv) begin
         a_period_ff <= period_in;
         a_pos_ff    <= pos_in;
         a_lb_ff     <= lb_in;
         a_row_ff    <= row_c[8:0];
         a_fetch_ff  <= (lb_in != '0) && req_data.fetch_enable;
      end
   end

   // stage b: cycle numerator, progress numerator, sample row
   logic                   b_vld_ff;
   logic [N1_W-1:0]        b_n1_ff;
   logic [29:0]            b_n3_ff;
   logic [21:0]            b_sy_ff;
   logic [PERIOD_BITS-1:0] b_period_ff;
   logic [13:0]            b_lb_ff;
   logic                   b_fetch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (adv) begin
         b_vld_ff <= a_vld_ff;
      end
      if (adv) begin
         b_n1_ff     <= N1_W'(a_period_ff) * N1_W'(vlfa_pkg::SYS_CLOCK_HZ)
                      + N1_W'(clk_eff - 27'd1);
         b_n3_ff     <= 30'(a_pos_ff) * 30'(a_lb_ff);
         b_sy_ff     <= 22'(offset_ff) + 22'(a_row_ff) * 22'(step_ff);
         b_period_ff <= a_period_ff;
         b_lb_ff     <= a_lb_ff;
         b_fetch_ff  <= a_fetch_ff;
      end
   end

   // stage c: row byte offset
   logic                   c_vld_ff;
   logic [N1_W-1:0]        c_n1_ff;
   logic [29:0]            c_n3_ff;
   logic [25:0]            c_yrow_ff;
   logic [PERIOD_BITS-1:0] c_period_ff;
   logic [13:0]            c_lb_ff;
   logic                   c_fetch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (adv) begin
         c_vld_ff <= b_vld_ff;
      end
      if (adv) begin
         c_n1_ff     <= b_n1_ff;
         c_n3_ff     <= b_n3_ff;
         c_yrow_ff   <= 26'(b_sy_ff[21:10]) * 26'(b_lb_ff);
         c_period_ff <= b_period_ff;
         c_lb_ff     <= b_lb_ff;
         c_fetch_ff  <= b_fetch_ff;
      end
   end

   // system cycle count and in-line progress dividers, run side by side
   logic            d1_vld;
   logic [N1_W-1:0] d1_q;
   logic [13:0]     d1_lb;
   logic            d3_vld;
   logic [N1_W-1:0] d3_q;
   logic [27:0]     d3_side;

   vlfa_div #(.NUM_W(N1_W), .DEN_W(27), .SIDE_W(14)) u_div_cycles (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (c_vld_ff),
      .num       (c_n1_ff),
      .den       (clk_eff),
      .side      (c_lb_ff),
      .out_valid (d1_vld),
      .quo       (d1_q),
      .out_side  (d1_lb)
   );

   vlfa_div #(.NUM_W(N1_W), .DEN_W(27), .SIDE_W(28)) u_div_progress (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (c_vld_ff),
      .num       (N1_W'(c_n3_ff)),
      .den       (27'(c_period_ff)),
      .side      ({c_fetch_ff, (c_period_ff == '0), c_yrow_ff}),
      .out_valid (d3_vld),
      .quo       (d3_q),
      .out_side  (d3_side)
   );

   // cycle count fix-up and address sum
   logic [N1_W-1:0]  cyc;
   logic [17:0]      cyc_sat;
   logic [31:0]      cyc_clip;
   logic [13:0]      prog;
   logic [SUM_W-1:0] addr_sum;
   logic [23:0]      addr_out;

   always_comb begin
      cyc      = (d1_q == '0) ? N1_W'(1) : d1_q;
      cyc_sat  = (cyc[N1_W-1:18] != '0) ? vlfa_pkg::CYCLES_MAX : cyc[17:0];
      cyc_clip = (cyc[N1_W-1:32] != '0) ? 32'hffffffff : cyc[31:0];
      prog     = d3_side[26] ? 14'd0 : {d3_q[13:3], 3'b000};
      addr_sum = (SUM_W'(origin_ff) + SUM_W'(d3_side[25:0]) + SUM_W'(prog)) & ADDR_MASK;
      addr_out = d3_side[27] ? addr_sum[23:0] : 24'd0;
   end

   // fetch interval divider
   logic            d2_vld;
   logic [N2_W-1:0] d2_q;
   logic [43:0]     d2_side;

   vlfa_div #(.NUM_W(N2_W), .DEN_W(14), .SIDE_W(44)) u_div_interval (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (d1_vld),
      .num       ({cyc_clip, 3'b000}),
      .den       (d1_lb),
      .side      ({d3_side[27], addr_out, cyc_sat, (d1_lb == '0)}),
      .out_valid (d2_vld),
      .quo       (d2_q),
      .out_side  (d2_side)
   );

   // interval limits and output register
   logic [19:0] interval;

   always_comb begin
      if (d2_side[0] || d2_q == '0) begin
         interval = 20'd1;
      end else if (d2_q[N2_W-1:20] != '0) begin
         interval = vlfa_pkg::INTERVAL_MAX;
      end else begin
         interval = d2_q[19:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= d2_vld;
      end
      if (adv) begin
         rsp_data_ff.address_valid      <= d2_side[43];
         rsp_data_ff.fetch_address      <= d2_side[42:19];
         rsp_data_ff.line_system_cycles <= d2_side[18:1];
         rsp_data_ff.fetch_interval     <= interval;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // the two parallel dividers stay in step
   a_div_sync : assert property (@(posedge clock) disable iff (reset)
      d1_vld == d3_vld)
      else $error("cycle and progress dividers out of step");

   // no fetch means a zero address
   a_no_fetch : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.address_valid |-> rsp_data.fetch_address == '0)
      else $error("address present without a fetch");

   // counts never reach zero
   a_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.line_system_cycles != '0 && rsp_data.fetch_interval != '0)
      else $error("zero cycle count or interval");

endmodule
